[hw/rtl/csvfrs_pkg.sv]
// Shared constants, codes and types of the CSV field and record scanner.
`timescale 1ns / 1ps

package csvfrs_pkg;

	// Syntax bytes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Column count saturation
	localparam int         MAX_COLUMNS = 255;
	localparam int         COL_CAP_INT = (MAX_COLUMNS < 255) ? MAX_COLUMNS : 255;
	localparam logic [7:0] COL_CAP     = 8'(COL_CAP_INT);

	// Configuration register map
	localparam int         CFG_IDX_W         = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_COLUMNS = 2'd1;
	localparam logic [7:0] DELIMITER_RESET     = 8'h2C;
	localparam logic [7:0] FIXED_COLUMNS_RESET = 8'h00;

	// column_status codes
	localparam logic [1:0] COL_OK      = 2'd0;
	localparam logic [1:0] COL_WARN    = 2'd1;
	localparam logic [1:0] COL_FATAL   = 2'd2;

	// quote_status codes
	localparam logic [1:0] QS_NONE       = 2'd0;
	localparam logic [1:0] QS_LONE_QUOTE = 2'd1;
	localparam logic [1:0] QS_UNBALANCED = 2'd2;
	localparam logic [1:0] QS_NO_NEWLINE = 2'd3;

	typedef struct packed {
		logic        inside_quotes;
		logic        inside_field;
		logic        quote_pending;
		logic        cr_pending;
		logic        bad_quote_seen;
		logic [7:0]  column_counter;
		logic [7:0]  expected_columns;
		logic        expected_known;
		logic [31:0] record_counter;
		logic        fatal_stop;
	} scan_state_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_content;
		logic        field_end;
		logic        record_end;
		logic [7:0]  columns_in_record;
		logic [31:0] record_number;
		logic [1:0]  column_status;
		logic [1:0]  quote_status;
		logic        halted;
	} scan_result_t;

endpackage

[hw/rtl/csvfrs_if.sv]
// Valid/ready channel interfaces for scanner input bytes and scan results.
`timescale 1ns / 1ps

interface csvfrs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvfrs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_content;
	logic        field_end;
	logic        record_end;
	logic [7:0]  columns_in_record;
	logic [31:0] record_number;
	logic [1:0]  column_status;
	logic [1:0]  quote_status;
	logic        halted;

	modport source (
		output valid, output out_byte, output is_content, output field_end,
		output record_end, output columns_in_record, output record_number,
		output column_status, output quote_status, output halted, input ready
	);
	modport sink (
		input valid, input out_byte, input is_content, input field_end,
		input record_end, input columns_in_record, input record_number,
		input column_status, input quote_status, input halted, output ready
	);
endinterface

[hw/rtl/csvfrs_step.sv]
// One-item next-state and result logic of the CSV scanner.
`timescale 1ns / 1ps

module csvfrs_step (
	input  logic [7:0]                delimiter,
	input  logic [7:0]                fixed_columns,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_input,
	input  csvfrs_pkg::scan_state_t   cur,
	output csvfrs_pkg::scan_state_t   nxt,
	output csvfrs_pkg::scan_result_t  res
);

	logic [7:0] col_inc;
	logic       is_quote;
	logic       is_delim;
	logic       is_nl;

	assign col_inc  = (cur.column_counter < csvfrs_pkg::COL_CAP) ?
		cur.column_counter + 8'd1 : cur.column_counter;
	assign is_quote = (data_byte == csvfrs_pkg::CH_QUOTE);
	assign is_delim = (data_byte == delimiter);
	assign is_nl    = (data_byte == csvfrs_pkg::CH_LF) || (data_byte == csvfrs_pkg::CH_CR);

	always_comb begin
		logic       do_close;
		logic       proceed;
		logic       eoi_close;
		logic [1:0] eoi_qs;

		nxt       = cur;
		res       = '0;
		res.columns_in_record = cur.column_counter;
		res.record_number     = cur.record_counter;
		do_close  = 1'b0;
		proceed   = 1'b0;
		eoi_close = 1'b0;
		eoi_qs    = csvfrs_pkg::QS_NO_NEWLINE;

		if (cur.fatal_stop) begin
			res.halted = 1'b1;
		end else if (end_of_input) begin
			nxt.cr_pending = 1'b0;
			if (cur.inside_field || cur.inside_quotes || cur.quote_pending ||
					cur.column_counter != 8'd0) begin
				do_close  = 1'b1;
				eoi_close = 1'b1;
				eoi_qs    = (cur.inside_quotes && !cur.quote_pending) ?
					csvfrs_pkg::QS_UNBALANCED : csvfrs_pkg::QS_NO_NEWLINE;
			end
		end else if (cur.quote_pending) begin
			// quote inside a quoted field: decide on the byte after it
			nxt.quote_pending = 1'b0;
			if (is_quote) begin
				res.out_byte   = data_byte;
				res.is_content = 1'b1;
				nxt.cr_pending = 1'b0;
			end else if (is_delim) begin
				nxt.inside_quotes  = 1'b0;
				nxt.inside_field   = 1'b0;
				nxt.column_counter = col_inc;
				res.field_end      = 1'b1;
				res.columns_in_record = col_inc;
				nxt.cr_pending     = 1'b0;
			end else if (is_nl) begin
				do_close       = 1'b1;
				nxt.cr_pending = (data_byte == csvfrs_pkg::CH_CR);
			end else begin
				// lone quote: drop it and handle the byte in the open field
				nxt.bad_quote_seen = 1'b1;
				proceed            = 1'b1;
			end
		end else begin
			proceed = 1'b1;
		end

		if (proceed) begin
			nxt.cr_pending = 1'b0;
			if (cur.cr_pending && data_byte == csvfrs_pkg::CH_LF) begin
				// absorb LF of a CR LF pair
			end else if (is_quote) begin
				if (cur.inside_quotes) begin
					nxt.quote_pending = 1'b1;
				end else if (!cur.inside_field) begin
					nxt.inside_field  = 1'b1;
					nxt.inside_quotes = 1'b1;
				end else begin
					res.out_byte   = data_byte;
					res.is_content = 1'b1;
				end
			end else if (is_delim) begin
				if (cur.inside_quotes) begin
					res.out_byte   = data_byte;
					res.is_content = 1'b1;
				end else begin
					nxt.inside_field   = 1'b0;
					nxt.column_counter = col_inc;
					res.field_end      = 1'b1;
					res.columns_in_record = col_inc;
				end
			end else if (is_nl) begin
				if (cur.inside_quotes) begin
					res.out_byte   = data_byte;
					res.is_content = 1'b1;
				end else begin
					do_close       = 1'b1;
					nxt.cr_pending = (data_byte == csvfrs_pkg::CH_CR);
				end
			end else begin
				nxt.inside_field = 1'b1;
				res.out_byte     = data_byte;
				res.is_content   = 1'b1;
			end
		end

		if (do_close) begin
			res.field_end         = 1'b1;
			res.record_end        = 1'b1;
			res.columns_in_record = col_inc;
			if (fixed_columns != 8'd0) begin
				if (col_inc != fixed_columns) begin
					res.column_status = csvfrs_pkg::COL_FATAL;
					nxt.fatal_stop    = 1'b1;
				end
			end else if (!cur.expected_known) begin
				nxt.expected_columns = col_inc;
				nxt.expected_known   = 1'b1;
			end else if (col_inc != cur.expected_columns) begin
				res.column_status = csvfrs_pkg::COL_WARN;
			end
			res.quote_status = cur.bad_quote_seen ?
				csvfrs_pkg::QS_LONE_QUOTE : csvfrs_pkg::QS_NONE;
			if (eoi_close) begin
				res.quote_status = eoi_qs;
			end
			res.halted         = nxt.fatal_stop;
			nxt.bad_quote_seen = 1'b0;
			nxt.column_counter = 8'd0;
			nxt.inside_field   = 1'b0;
			nxt.inside_quotes  = 1'b0;
			nxt.quote_pending  = 1'b0;
			if (cur.record_counter != 32'hFFFF_FFFF) begin
				nxt.record_counter = cur.record_counter + 32'd1;
			end
		end
	end

endmodule

[hw/rtl/csv_field_record_scanner_top.sv]
// Top level of the CSV field and record scanner: channels, config and pipeline.
//
//   channel   direction  payload                                   handshake
//   in_ch     in         data_byte, end_of_input                   valid/ready
//   out_ch    out        out_byte .. halted (one result per item)  valid/ready
//   cfg       in         cfg_index, cfg_wdata                      cfg_we only
//
// One item per clock sustained while the output is not stalled. An input transfer
// loads the input register; the item then moves into the result register, from
// which its result transfers out.
// The scan state advances when the input register moves into the result
// register, so the byte-to-byte dependency is a single combinational path.
// arst_n clears the state, the valid flags and the config registers to their
// reset values. A stalled output holds its result; the input register keeps
// taking a new byte whenever the item ahead of it can move on.
`timescale 1ns / 1ps

module csv_field_record_scanner_top (
	input  logic                                clk,
	input  logic                                arst_n,
	csvfrs_in_if.sink                           in_ch,
	csvfrs_out_if.source                        out_ch,
	input  logic                                cfg_we,
	input  logic [csvfrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_wdata
);

	// Configuration registers
	logic [7:0] delimiter_q;
	logic [7:0] fixed_columns_q;

	// Input register stage
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       eoi_s1;

	// Result register stage
	logic                     out_valid_q;
	csvfrs_pkg::scan_result_t res_q;

	// Scan state
	csvfrs_pkg::scan_state_t  st_q;
	csvfrs_pkg::scan_state_t  st_nxt;
	csvfrs_pkg::scan_result_t res_nxt;

	logic advance;
	logic in_xfer;

	// advance the input stage when the result register is free or draining
	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_xfer = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q     <= csvfrs_pkg::DELIMITER_RESET;
			fixed_columns_q <= csvfrs_pkg::FIXED_COLUMNS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csvfrs_pkg::REG_DELIMITER:     delimiter_q     <= cfg_wdata;
				csvfrs_pkg::REG_FIXED_COLUMNS: fixed_columns_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_byte_s1 <= in_ch.data_byte;
			eoi_s1       <= in_ch.end_of_input;
		end
	end

	csvfrs_step u_step (
		.delimiter     (delimiter_q),
		.fixed_columns (fixed_columns_q),
		.data_byte     (data_byte_s1),
		.end_of_input  (eoi_s1),
		.cur           (st_q),
		.nxt           (st_nxt),
		.res           (res_nxt)
	);

	// scan state: commit once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.out_byte          = res_q.out_byte;
	assign out_ch.is_content        = res_q.is_content;
	assign out_ch.field_end         = res_q.field_end;
	assign out_ch.record_end        = res_q.record_end;
	assign out_ch.columns_in_record = res_q.columns_in_record;
	assign out_ch.record_number     = res_q.record_number;
	assign out_ch.column_status     = res_q.column_status;
	assign out_ch.quote_status      = res_q.quote_status;
	assign out_ch.halted            = res_q.halted;

`ifndef SYNTHESIS
	// a fatal stop lasts until reset
	a_fatal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fatal_stop |=> st_q.fatal_stop)
		else $error("fatal stop cleared without reset");

	// a record close always closes its last field too
	a_record_has_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.record_end |-> res_q.field_end)
		else $error("record end without field end");

	// a held input item stays put while the result side is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_byte_s1) && $stable(eoi_s1))
		else $error("input stage lost a stalled item");

	// the column count never passes its cap
	a_col_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.column_counter <= csvfrs_pkg::COL_CAP)
		else $error("column counter above cap");
`endif

endmodule
